// ===== rtl/cassette_tape_image_framer_assert.svh =====
// Assertion macros shared by the framer RTL.
`ifndef CASSETTE_TAPE_IMAGE_FRAMER_ASSERT_SVH
`define CASSETTE_TAPE_IMAGE_FRAMER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CTIF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CTIF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CTIF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define CTIF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/ctif_pkg.sv =====
package ctif_pkg;

   localparam logic FUNC_BEGIN = 1'b0;
   localparam logic FUNC_DATA  = 1'b1;

   localparam logic [1:0] CSR_FILE_NAME     = 2'd0;
   localparam logic [1:0] CSR_FILE_SIZE     = 2'd1;
   localparam logic [1:0] CSR_LOAD_ADDRESS  = 2'd2;
   localparam logic [1:0] CSR_START_ADDRESS = 2'd3;

   localparam logic [39:0] FILE_NAME_RESET = 40'h2020202020;

   localparam logic [7:0] SYNC_BYTE   = 8'h01;
   localparam logic [7:0] HEADER_ID   = 8'h55;
   localparam logic [7:0] ZERO_BYTE   = 8'h00;
   localparam logic [7:0] SUM_INVERT  = 8'hFF;
   localparam logic [6:0] REPEAT_ONE  = 7'd1;

   // sequencer steps of the preamble
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_LEAD1     = 5'd0;
   localparam logic [STEP_W-1:0] STEP_SYNC1     = 5'd1;
   localparam logic [STEP_W-1:0] STEP_HDR_FIRST = 5'd2;
   localparam logic [STEP_W-1:0] STEP_HDR_LAST  = 5'd17;
   localparam logic [STEP_W-1:0] STEP_HDR_SUM   = 5'd18;
   localparam logic [STEP_W-1:0] STEP_LEAD2     = 5'd19;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_BEGIN,
      CMD_PASS,
      CMD_CHUNK,
      CMD_ERROR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data_byte;
      logic [7:0]   chunk_sum;
      logic         end_of_tape;
   } cmd_type;

   typedef struct packed {
      logic [39:0] file_name;
      logic [15:0] file_size;
      logic [15:0] load_address;
      logic [15:0] start_address;
   } hdr_cfg_type;

   function automatic logic [7:0] sum_step(input logic [7:0] crc, input logic [7:0] b);
      sum_step = (b - crc) ^ SUM_INVERT;
   endfunction

endpackage

// ===== rtl/ctif_front.sv =====
module ctif_front #(
   parameter int CHUNK_BYTES = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 q_full,
   input  logic                 req_func,
   input  logic [7:0]           req_data_byte,
   input  logic [15:0]          file_size,
   output logic                 push,
   output ctif_pkg::cmd_type    cmd
);

   localparam int POS_W = $clog2(CHUNK_BYTES);

   logic [7:0]       csum_ff, csum_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      sent_ff, sent_in;
   logic             active_ff, active_in;

   logic        data_ok;
   logic [7:0]  sum_new;
   logic [15:0] sent_next;
   logic        final_byte;
   logic        chunk_end;

   assign push       = req_valid && !q_full;
   assign data_ok    = active_ff && (sent_ff < file_size);
   assign sum_new    = ctif_pkg::sum_step(csum_ff, req_data_byte);
   assign sent_next  = sent_ff + 16'd1;
   assign final_byte = sent_next >= file_size;
   assign chunk_end  = pos_ff == POS_W'(CHUNK_BYTES - 1);

   always_comb begin
      csum_in   = csum_ff;
      pos_in    = pos_ff;
      sent_in   = sent_ff;
      active_in = active_ff;
      cmd.kind        = ctif_pkg::CMD_ERROR;
      cmd.data_byte   = req_data_byte;
      cmd.chunk_sum   = sum_new;
      cmd.end_of_tape = final_byte;
      priority if (req_func == ctif_pkg::FUNC_BEGIN) begin
         cmd.kind  = ctif_pkg::CMD_BEGIN;
         csum_in   = '0;
         pos_in    = '0;
         sent_in   = '0;
         active_in = file_size != 16'd0;
      end else if (!data_ok) begin
         cmd.kind = ctif_pkg::CMD_ERROR;
      end else if (chunk_end || final_byte) begin
         cmd.kind = ctif_pkg::CMD_CHUNK;
         csum_in  = '0;
         pos_in   = '0;
         sent_in  = sent_next;
         if (final_byte) begin
            active_in = 1'b0;
         end
      end else begin
         cmd.kind = ctif_pkg::CMD_PASS;
         csum_in  = sum_new;
         pos_in   = pos_ff + POS_W'(1);
         sent_in  = sent_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csum_ff   <= '0;
         pos_ff    <= '0;
         sent_ff   <= '0;
         active_ff <= 1'b0;
      end else if (push) begin
         csum_ff   <= csum_in;
         pos_ff    <= pos_in;
         sent_ff   <= sent_in;
         active_ff <= active_in;
      end
   end

endmodule

// ===== rtl/ctif_queue.sv =====
module ctif_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ctif_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output ctif_pkg::cmd_type head_cmd
);

   localparam int PTR_W = $clog2(ctif_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ctif_pkg::QUEUE_DEPTH + 1);

   ctif_pkg::cmd_type  mem_ff [ctif_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full       = cnt_ff == CNT_W'(ctif_pkg::QUEUE_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_cmd   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/ctif_back.sv =====
module ctif_back #(
   parameter int LEAD_ZEROS = 100
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  ctif_pkg::cmd_type     head_cmd,
   input  ctif_pkg::hdr_cfg_type cfg,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_tape_byte,
   output logic [6:0]            rsp_repeat_count,
   output logic                  rsp_end_of_tape,
   output logic                  rsp_error,
   output logic                  rsp_last
);

   localparam logic [6:0] LEAD_REP = 7'(LEAD_ZEROS);

   logic [ctif_pkg::STEP_W-1:0] step_ff, step_in;
   logic [7:0]                  hcrc_ff, hcrc_in;
   logic                        valid_ff, valid_in;
   logic [7:0]                  byte_ff;
   logic [6:0]                  rep_ff;
   logic                        eot_ff, err_ff, last_ff;

   logic                        load;
   logic                        advance;
   logic [ctif_pkg::STEP_W-1:0] hdr_off;
   logic [3:0]                  hdr_idx;
   logic [7:0]                  hdr_byte;
   logic                        in_hdr;
   logic [7:0]                  b_byte;
   logic [6:0]                  b_rep;
   logic                        b_eot, b_err, b_last;

   assign load    = !valid_ff || !rsp_stall;
   assign advance = head_valid && load;
   assign pop     = advance && b_last;
   assign hdr_off = step_ff - ctif_pkg::STEP_HDR_FIRST;
   assign hdr_idx = hdr_off[3:0];
   assign in_hdr  = (step_ff >= ctif_pkg::STEP_HDR_FIRST) &&
                    (step_ff <= ctif_pkg::STEP_HDR_LAST);

   always_comb begin
      unique case (hdr_idx)
         4'd0:    hdr_byte = cfg.file_name[7:0];
         4'd1:    hdr_byte = cfg.file_name[15:8];
         4'd2:    hdr_byte = cfg.file_name[23:16];
         4'd3:    hdr_byte = cfg.file_name[31:24];
         4'd4:    hdr_byte = cfg.file_name[39:32];
         4'd5:    hdr_byte = ctif_pkg::HEADER_ID;
         4'd7:    hdr_byte = cfg.file_size[7:0];
         4'd8:    hdr_byte = cfg.file_size[15:8];
         4'd9:    hdr_byte = cfg.load_address[7:0];
         4'd10:   hdr_byte = cfg.load_address[15:8];
         4'd11:   hdr_byte = cfg.start_address[7:0];
         4'd12:   hdr_byte = cfg.start_address[15:8];
         default: hdr_byte = ctif_pkg::ZERO_BYTE;
      endcase
   end

   // beat for the current command and step
   always_comb begin
      b_byte = ctif_pkg::ZERO_BYTE;
      b_rep  = ctif_pkg::REPEAT_ONE;
      b_eot  = 1'b0;
      b_err  = 1'b0;
      b_last = 1'b0;
      unique case (head_cmd.kind)
         ctif_pkg::CMD_BEGIN: begin
            priority if (step_ff == ctif_pkg::STEP_LEAD1 ||
                         step_ff == ctif_pkg::STEP_LEAD2) begin
               b_rep = LEAD_REP;
            end else if (step_ff == ctif_pkg::STEP_SYNC1) begin
               b_byte = ctif_pkg::SYNC_BYTE;
            end else if (in_hdr) begin
               b_byte = hdr_byte;
            end else if (step_ff == ctif_pkg::STEP_HDR_SUM) begin
               b_byte = hcrc_ff;
            end else begin
               b_byte = ctif_pkg::SYNC_BYTE;
               b_last = 1'b1;
            end
         end
         ctif_pkg::CMD_PASS: begin
            b_byte = head_cmd.data_byte;
            b_last = 1'b1;
         end
         ctif_pkg::CMD_CHUNK: begin
            if (step_ff == ctif_pkg::STEP_LEAD1) begin
               b_byte = head_cmd.data_byte;
            end else begin
               b_byte = head_cmd.chunk_sum;
               b_eot  = head_cmd.end_of_tape;
               b_last = 1'b1;
            end
         end
         ctif_pkg::CMD_ERROR: begin
            b_err  = 1'b1;
            b_last = 1'b1;
         end
         default: begin
            b_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      hcrc_in  = hcrc_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = head_valid;
      end
      if (advance) begin
         step_in = b_last ? '0 : step_ff + ctif_pkg::STEP_W'(1);
         if (head_cmd.kind == ctif_pkg::CMD_BEGIN && in_hdr) begin
            hcrc_in = ctif_pkg::sum_step(
               (step_ff == ctif_pkg::STEP_HDR_FIRST) ? ctif_pkg::ZERO_BYTE : hcrc_ff,
               hdr_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hcrc_ff <= hcrc_in;
      if (advance) begin
         byte_ff <= b_byte;
         rep_ff  <= b_rep;
         eot_ff  <= b_eot;
         err_ff  <= b_err;
         last_ff <= b_last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_tape_byte    = byte_ff;
   assign rsp_repeat_count = rep_ff;
   assign rsp_end_of_tape  = eot_ff;
   assign rsp_error        = err_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== rtl/cassette_tape_image_framer.sv =====
// channel  direction  beat
// req_     in         func, data_byte
// rsp_     out        tape_byte, repeat_count, end_of_tape, error, last
// csr_     in         index (2 bits), data (40 bits), always ready
//
// The front classifies an item and updates the image state in the cycle it
// is taken; a two-entry command queue feeds the back sequencer.
// The back emits one beat per cycle while a command waits and no rsp_stall:
// a data byte; a closing byte then its chunk sum; a begin's preamble steps.
// req_stall rises only while the command queue is full; rsp_stall holds the
// output register and, through it, the sequencer. Reset is synchronous and
// clears the image state, the queue and the output valid.
`include "cassette_tape_image_framer_assert.svh"

module cassette_tape_image_framer #(
   parameter int CHUNK_BYTES = 256,
   parameter int LEAD_ZEROS  = 100
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tape_byte,
   output logic [6:0]  rsp_repeat_count,
   output logic        rsp_end_of_tape,
   output logic        rsp_error,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [39:0] csr_data
);

   ctif_pkg::hdr_cfg_type cfg_ff;
   ctif_pkg::cmd_type     push_cmd;
   ctif_pkg::cmd_type     head_cmd;
   logic                  push;
   logic                  pop;
   logic                  q_full;
   logic                  head_valid;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.file_name     <= ctif_pkg::FILE_NAME_RESET;
         cfg_ff.file_size     <= '0;
         cfg_ff.load_address  <= '0;
         cfg_ff.start_address <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ctif_pkg::CSR_FILE_NAME:     cfg_ff.file_name     <= csr_data;
            ctif_pkg::CSR_FILE_SIZE:     cfg_ff.file_size     <= csr_data[15:0];
            ctif_pkg::CSR_LOAD_ADDRESS:  cfg_ff.load_address  <= csr_data[15:0];
            ctif_pkg::CSR_START_ADDRESS: cfg_ff.start_address <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   ctif_front #(
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .q_full        (q_full),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .file_size     (cfg_ff.file_size),
      .push          (push),
      .cmd           (push_cmd)
   );

   ctif_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   ctif_back #(
      .LEAD_ZEROS (LEAD_ZEROS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .cfg              (cfg_ff),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tape_byte    (rsp_tape_byte),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_end_of_tape  (rsp_end_of_tape),
      .rsp_error        (rsp_error),
      .rsp_last         (rsp_last)
   );

   `CTIF_ASSERT_IMPLY(a_eot_is_last, clock, reset, rsp_valid && rsp_end_of_tape, rsp_last && !rsp_error, "end_of_tape off the final beat")
   `CTIF_ASSERT_IMPLY(a_err_is_single, clock, reset, rsp_valid && rsp_error, rsp_last && rsp_tape_byte == 8'h00, "malformed error beat")
   `CTIF_ASSERT_IMPLY(a_lead_shape, clock, reset, rsp_valid && rsp_repeat_count != 7'd1, rsp_tape_byte == 8'h00 && !rsp_last, "lead beat malformed")
   `CTIF_ASSERT_IMPLY(a_pop_needs_head, clock, reset, !head_valid, !pop, "queue popped while empty")

endmodule

// ===== tb/testbench.sv =====
module testbench;

   localparam int CLOCK_HALF      = 4;
   localparam int RESET_CYCLES    = 12;
   localparam int CHUNK_LEN       = 256;
   localparam int LEAD_LEN        = 100;
   localparam int BURST_BYTES     = 24;
   localparam int RANDOM_ITEMS    = 75;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int MAX_REPORTS     = 10;
   localparam bit [6:0] LEAD_REPEAT = 7'(LEAD_LEN);

   typedef struct packed {
      logic [7:0] tape_byte;
      logic [6:0] repeat_count;
      logic       end_of_tape;
      logic       error;
      logic       last;
   } tape_beat_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;
   typedef enum {
      SHAPE_NOISE, SHAPE_SHORT, SHAPE_RESIZE, SHAPE_OVERRUN, SHAPE_CLEAN
   } image_shape_type;

   // tape stream predictor plus the queue of beats still owed by the block
   class tape_scoreboard;
      bit [39:0]     file_name;
      bit [15:0]     file_size;
      bit [15:0]     load_address;
      bit [15:0]     start_address;
      bit [7:0]      chunk_sum;
      int            chunk_fill;
      bit [15:0]     bytes_taken;
      bit            image_open;
      tape_beat_type pending[$];
      int            failures;

      function new();
         file_name     = ctif_pkg::FILE_NAME_RESET;
         file_size     = '0;
         load_address  = '0;
         start_address = '0;
         chunk_sum     = '0;
         chunk_fill    = 0;
         bytes_taken   = '0;
         image_open    = 1'b0;
         failures      = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [39:0] value);
         case (index)
            ctif_pkg::CSR_FILE_NAME:     file_name     = value;
            ctif_pkg::CSR_FILE_SIZE:     file_size     = value[15:0];
            ctif_pkg::CSR_LOAD_ADDRESS:  load_address  = value[15:0];
            ctif_pkg::CSR_START_ADDRESS: start_address = value[15:0];
            default: ;
         endcase
      endfunction

      function bit [7:0] fold(bit [7:0] sum, bit [7:0] b);
         return (b - sum) ^ 8'hFF;
      endfunction

      function void push(bit [7:0] tb, bit [6:0] rep, bit eot, bit err, bit lst);
         pending.push_back('{tape_byte: tb, repeat_count: rep, end_of_tape: eot,
                             error: err, last: lst});
      endfunction

      function void note_item(logic func, logic [7:0] b);
         bit [7:0] hdr [16];
         bit [7:0] sum;
         bit       final_byte;
         int       i;
         if (func == ctif_pkg::FUNC_BEGIN) begin
            for (i = 0; i < 5; i++) hdr[i] = file_name[8*i +: 8];
            hdr[5]  = ctif_pkg::HEADER_ID;
            hdr[6]  = ctif_pkg::ZERO_BYTE;
            hdr[7]  = file_size[7:0];
            hdr[8]  = file_size[15:8];
            hdr[9]  = load_address[7:0];
            hdr[10] = load_address[15:8];
            hdr[11] = start_address[7:0];
            hdr[12] = start_address[15:8];
            hdr[13] = ctif_pkg::ZERO_BYTE;
            hdr[14] = ctif_pkg::ZERO_BYTE;
            hdr[15] = ctif_pkg::ZERO_BYTE;
            push(ctif_pkg::ZERO_BYTE, LEAD_REPEAT, 1'b0, 1'b0, 1'b0);
            push(ctif_pkg::SYNC_BYTE, 7'd1, 1'b0, 1'b0, 1'b0);
            sum = '0;
            for (i = 0; i < 16; i++) begin
               push(hdr[i], 7'd1, 1'b0, 1'b0, 1'b0);
               sum = fold(sum, hdr[i]);
            end
            push(sum, 7'd1, 1'b0, 1'b0, 1'b0);
            push(ctif_pkg::ZERO_BYTE, LEAD_REPEAT, 1'b0, 1'b0, 1'b0);
            push(ctif_pkg::SYNC_BYTE, 7'd1, 1'b0, 1'b0, 1'b1);
            chunk_sum   = '0;
            chunk_fill  = 0;
            bytes_taken = '0;
            image_open  = (file_size != 0);
         end else if (!image_open || bytes_taken >= file_size) begin
            push(ctif_pkg::ZERO_BYTE, 7'd1, 1'b0, 1'b1, 1'b1);
         end else begin
            chunk_sum   = fold(chunk_sum, b);
            bytes_taken = bytes_taken + 16'd1;
            chunk_fill++;
            // size register is re-read on every byte
            final_byte  = (bytes_taken >= file_size);
            if (chunk_fill >= CHUNK_LEN || final_byte) begin
               push(b, 7'd1, 1'b0, 1'b0, 1'b0);
               push(chunk_sum, 7'd1, final_byte, 1'b0, 1'b1);
               chunk_sum  = '0;
               chunk_fill = 0;
               if (final_byte) image_open = 1'b0;
            end else begin
               push(b, 7'd1, 1'b0, 1'b0, 1'b1);
            end
         end
      endfunction

      function void report(string what, tape_beat_type want, tape_beat_type got);
         failures++;
         if (failures <= MAX_REPORTS)
            $display({"%s: expected byte %h rep %0d eot %b err %b last %b, ",
                      "got byte %h rep %0d eot %b err %b last %b"},
                     what, want.tape_byte, want.repeat_count, want.end_of_tape, want.error,
                     want.last, got.tape_byte, got.repeat_count, got.end_of_tape, got.error,
                     got.last);
      endfunction

      function void check_beat(tape_beat_type got);
         tape_beat_type want;
         if (pending.size() == 0) begin
            report("unexpected beat", '0, got);
         end else begin
            want = pending.pop_front();
            if (got.tape_byte !== want.tape_byte || got.repeat_count !== want.repeat_count ||
                got.end_of_tape !== want.end_of_tape || got.error !== want.error ||
                got.last !== want.last)
               report("beat mismatch", want, got);
         end
      endfunction

      function int close_out();
         while (pending.size() != 0) report("missing beat", pending.pop_front(), '0);
         return failures;
      endfunction
   endclass

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_func      = ctif_pkg::FUNC_BEGIN;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_stall     = 1'b0;
   logic        csr_valid     = 1'b0;
   logic [1:0]  csr_index     = ctif_pkg::CSR_FILE_NAME;
   logic [39:0] csr_data      = '0;
   logic        req_stall;
   logic        rsp_valid;
   logic [7:0]  rsp_tape_byte;
   logic [6:0]  rsp_repeat_count;
   logic        rsp_end_of_tape;
   logic        rsp_error;
   logic        rsp_last;
   logic        csr_ready;

   tape_scoreboard sb = new();
   int  cycle_count  = 0;
   int  items_sent   = 0;
   int  burst_left   = 0;
   bit  no_gaps      = 1'b0;
   bit  hold_off_req = 1'b0;

   cassette_tape_image_framer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tape_byte    (rsp_tape_byte),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_end_of_tape  (rsp_end_of_tape),
      .rsp_error        (rsp_error),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: checks beats, stalls in modes of random length, long hold on request
   initial begin
      stall_mode_type mode;
      int             mode_left;
      int             hold_left;
      bit             stall_next;
      mode      = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_beat('{tape_byte: rsp_tape_byte, repeat_count: rsp_repeat_count,
                            end_of_tape: rsp_end_of_tape, error: rsp_error,
                            last: rsp_last});
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
               STALL_NONE:  stall_next = 1'b0;
               STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
               STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
               default:     stall_next = ~rsp_stall;
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   task automatic send_item(logic func, logic [7:0] b);
      req_valid     <= 1'b1;
      req_func      <= func;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      sb.note_item(func, b);
      items_sent++;
      if (!no_gaps) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         end
      end
   endtask

   // sender goes quiet until every owed beat has come back
   task automatic finish_phase();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
   endtask

   task automatic set_registers(bit [3:0] which, logic [39:0] name, logic [15:0] size,
                                logic [15:0] load, logic [15:0] start);
      logic [1:0]  index [4];
      logic [39:0] value [4];
      int          i;
      index = '{ctif_pkg::CSR_FILE_NAME, ctif_pkg::CSR_FILE_SIZE,
                ctif_pkg::CSR_LOAD_ADDRESS, ctif_pkg::CSR_START_ADDRESS};
      value = '{name, 40'(size), 40'(load), 40'(start)};
      for (i = 0; i < 4; i++) begin
         if (which[i]) begin
            csr_valid <= 1'b1;
            csr_index <= index[i];
            csr_data  <= value[i];
            do @(posedge clock); while (!csr_ready);
            sb.write_reg(index[i], value[i]);
         end
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_image();
      image_shape_type shape;
      logic [39:0]     name;
      logic [15:0]     size;
      logic [15:0]     load;
      logic [15:0]     start;
      int              n;
      int              i;
      finish_phase();
      case ($urandom_range(0, 3))
         0:       name = '0;
         1:       name = '1;
         default: name = 40'({$urandom(), $urandom()});
      endcase
      case ($urandom_range(0, 9))
         0:       size = 16'd0;
         8:       size = 16'($urandom_range(13, 40));
         9:       size = 16'($urandom());
         default: size = 16'($urandom_range(1, 12));
      endcase
      load  = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                          : 16'($urandom());
      start = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                          : 16'($urandom());
      set_registers(4'($urandom_range(0, 15)), name, size, load, start);
      n = (sb.file_size > 40) ? $urandom_range(1, 10) : int'(sb.file_size);
      case ($urandom_range(0, 9))
         0:       shape = SHAPE_NOISE;
         1:       shape = SHAPE_SHORT;
         2:       shape = SHAPE_RESIZE;
         3:       shape = SHAPE_OVERRUN;
         default: shape = SHAPE_CLEAN;
      endcase
      if (shape == SHAPE_NOISE) begin
         repeat ($urandom_range(1, 6))
            send_item($urandom_range(0, 3) == 0 ? ctif_pkg::FUNC_BEGIN : ctif_pkg::FUNC_DATA,
                      8'($urandom_range(0, 255)));
      end else begin
         send_item(ctif_pkg::FUNC_BEGIN, 8'($urandom_range(0, 255)));
         if (shape == SHAPE_SHORT) n = $urandom_range(0, n);
         for (i = 0; i < n; i++) begin
            send_item(ctif_pkg::FUNC_DATA, 8'($urandom_range(0, 255)));
            if (shape == SHAPE_RESIZE && i == n / 2) begin
               finish_phase();
               set_registers(4'b0010, '0, 16'($urandom_range(0, n + 2)), '0, '0);
            end
         end
         if (shape == SHAPE_OVERRUN)
            repeat ($urandom_range(1, 3))
               send_item(ctif_pkg::FUNC_DATA, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int i;
      int random_base;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: data with no image open, then an empty image
      send_item(ctif_pkg::FUNC_DATA, 8'hFF);
      send_item(ctif_pkg::FUNC_BEGIN, 8'h00);
      send_item(ctif_pkg::FUNC_DATA, 8'h00);
      finish_phase();

      set_registers(4'b1111, 40'hFF_FFFF_FFFF, 16'd3, 16'hFFFF, 16'h0000);
      send_item(ctif_pkg::FUNC_BEGIN, 8'hFF);
      send_item(ctif_pkg::FUNC_DATA, 8'h00);
      send_item(ctif_pkg::FUNC_DATA, 8'hFF);
      send_item(ctif_pkg::FUNC_DATA, 8'h80);
      send_item(ctif_pkg::FUNC_DATA, 8'h7F);
      finish_phase();

      // max size, then a restart abandoning the open image
      set_registers(4'b1111, 40'h0, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_item(ctif_pkg::FUNC_BEGIN, 8'h00);
      send_item(ctif_pkg::FUNC_DATA, 8'hA5);
      send_item(ctif_pkg::FUNC_DATA, 8'h5A);
      send_item(ctif_pkg::FUNC_BEGIN, 8'h5A);
      send_item(ctif_pkg::FUNC_DATA, 8'h01);
      finish_phase();

      set_registers(4'b1111, 40'h4F_4C4C_4548, 16'd1, 16'h1234, 16'h5678);
      send_item(ctif_pkg::FUNC_BEGIN, 8'h00);
      send_item(ctif_pkg::FUNC_DATA, 8'h55);
      send_item(ctif_pkg::FUNC_DATA, 8'hC3);
      finish_phase();

      // shrink the size under an open image
      set_registers(4'b0010, '0, 16'd2, '0, '0);
      send_item(ctif_pkg::FUNC_BEGIN, 8'h00);
      send_item(ctif_pkg::FUNC_DATA, 8'h3C);
      finish_phase();
      set_registers(4'b0010, '0, 16'd1, '0, '0);
      send_item(ctif_pkg::FUNC_DATA, 8'hC3);
      finish_phase();

      // image sent back to back into a held-off receiver
      set_registers(4'b0010, '0, 16'(BURST_BYTES), '0, '0);
      no_gaps      = 1'b1;
      hold_off_req = 1'b1;
      send_item(ctif_pkg::FUNC_BEGIN, 8'h00);
      for (i = 0; i < BURST_BYTES; i++)
         send_item(ctif_pkg::FUNC_DATA, 8'($urandom_range(0, 255)));
      no_gaps = 1'b0;
      finish_phase();

      random_base = items_sent;
      while (items_sent - random_base < RANDOM_ITEMS) run_random_image();
      finish_phase();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.close_out() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
